FILE: src/pwfd_pkg.sv
// shared types and constants for the ir pulse width frame decoder
`default_nettype none
package pwfd_pkg;

    localparam int unsigned WIDTH_W = 8;
    localparam int unsigned DEV_ID_W = 5;
    localparam int unsigned CMD_W = 3;
    localparam int unsigned FRAME_BITS = 8;
    localparam int unsigned COUNT_W = 4;

    localparam logic [WIDTH_W-1:0] SYNC_LO = 8'd72;
    localparam logic [WIDTH_W-1:0] SYNC_HI = 8'd82;
    localparam logic [WIDTH_W-1:0] ONE_LO = 8'd33;
    localparam logic [WIDTH_W-1:0] ONE_HI = 8'd43;
    localparam logic [WIDTH_W-1:0] ZERO_LO = 8'd14;
    localparam logic [WIDTH_W-1:0] ZERO_HI = 8'd24;
    localparam logic [COUNT_W-1:0] FRAME_LEN = 4'd8;

    typedef logic [WIDTH_W-1:0] t_width;
    typedef logic [DEV_ID_W-1:0] t_dev_id;

    typedef enum logic [CMD_W-1:0] {
        CMD_LIGHT = 3'd1,
        CMD_DARK  = 3'd2
    } t_cmd;

    typedef struct packed {
        logic   valid;
        t_width width;
    } t_step;

endpackage
`default_nettype wire

FILE: src/pwfd_pulse_if.sv
// handshake channel carrying one pulse width word
`default_nettype none
interface pwfd_pulse_if
    import pwfd_pkg::*;
;
    logic   valid;
    logic   ready;
    t_width pulse_width;

    modport source (output valid, output pulse_width, input ready);
    modport sink (input valid, input pulse_width, output ready);
endinterface
`default_nettype wire

FILE: src/pwfd_led_if.sv
// handshake channel carrying one led level word
`default_nettype none
interface pwfd_led_if;
    logic valid;
    logic ready;
    logic led_on;

    modport source (output valid, output led_on, input ready);
    modport sink (input valid, input led_on, output ready);
endinterface
`default_nettype wire

FILE: src/ir_pulse_width_frame_decoder_unit.sv
// top level of the ir pulse width frame decoder
// an accepted word passes through the input register and then the result register before its led word is offered
// one word per cycle while the led output is empty or ready, set by the input and result registers
// a held result does not block intake while the input register is free
// reset (synchronous, active low) clears the frame, led level and device id
`default_nettype none
module ir_pulse_width_frame_decoder_unit
    import pwfd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    pwfd_pulse_if.sink   i_pulse,
    pwfd_led_if.source   o_led,
    input  wire          i_cfg_wr_en,
    input  wire t_dev_id i_cfg_wr_data
);

    logic    r_in_valid;
    t_width  r_in_width;
    logic    r_out_valid;
    logic    r_out_led;
    t_dev_id r_dev_id;

    logic    adv_out;
    logic    adv_in;
    logic    led_next;
    t_step   step;

    assign adv_out = !r_out_valid || o_led.ready;
    assign adv_in  = !r_in_valid || adv_out;
    assign i_pulse.ready = adv_in;

    assign step.valid = r_in_valid && adv_out;
    assign step.width = r_in_width;

    pwfd_frame_ctrl u_frame_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_dev_id   (r_dev_id),
        .o_led_next (led_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dev_id    <= '0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_pulse.valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_wr_en) begin
                r_dev_id <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_pulse.valid) begin
            r_in_width <= i_pulse.pulse_width;
        end
        if (step.valid) begin
            r_out_led <= led_next;
        end
    end

    assign o_led.valid  = r_out_valid;
    assign o_led.led_on = r_out_led;

endmodule
`default_nettype wire

FILE: src/pwfd_frame_ctrl.sv
// pulse classification, frame assembly and led state
`default_nettype none
module pwfd_frame_ctrl
    import pwfd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_step  i_step,
    input  wire t_dev_id i_dev_id,
    output logic        o_led_next
);

    logic                  r_in_frame;
    logic [COUNT_W-1:0]    r_count;
    logic [FRAME_BITS-1:0] r_bits;
    logic                  r_led;

    logic                  n_in_frame;
    logic [COUNT_W-1:0]    n_count;
    logic [FRAME_BITS-1:0] n_bits;
    logic                  n_led;

    logic                  is_sync;
    logic                  is_one;
    logic                  is_zero;
    logic [FRAME_BITS-1:0] shifted;
    logic [COUNT_W-1:0]    count_inc;
    logic [CMD_W-1:0]      cmd;
    t_dev_id               data;

    assign is_sync = (i_step.width > SYNC_LO) && (i_step.width < SYNC_HI);
    assign is_one  = (i_step.width > ONE_LO) && (i_step.width < ONE_HI);
    assign is_zero = (i_step.width > ZERO_LO) && (i_step.width < ZERO_HI);
    assign shifted = {r_bits[FRAME_BITS-2:0], is_one};
    assign count_inc = r_count + COUNT_W'(1);
    assign cmd  = shifted[FRAME_BITS-1 -: CMD_W];
    assign data = shifted[DEV_ID_W-1:0];

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_bits     = r_bits;
        n_led      = r_led;
        if (is_sync) begin
            n_in_frame = 1'b1;
            n_count    = '0;
            n_bits     = '0;
        end else if (r_in_frame && (is_one || is_zero)) begin
            n_bits  = shifted;
            n_count = count_inc;
            if (count_inc >= FRAME_LEN) begin
                n_in_frame = 1'b0;
                n_count    = '0;
                n_bits     = '0;
                case (cmd)
                    CMD_LIGHT: n_led = (i_dev_id <= data);
                    CMD_DARK:  n_led = 1'b0;
                    default:   n_led = r_led;
                endcase
            end
        end
    end

    assign o_led_next = n_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_bits     <= '0;
            r_led      <= 1'b0;
        end else if (i_step.valid) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_bits     <= n_bits;
            r_led      <= n_led;
        end
    end

endmodule
`default_nettype wire
